>>> hw/rtl/http_request_line_parser_assert.svh
// Assertion macros for the request line parser checker (hrlp_checker).
// No dependencies; include by bare file name.
`ifndef HTTP_REQUEST_LINE_PARSER_ASSERT_SVH
`define HTTP_REQUEST_LINE_PARSER_ASSERT_SVH

// Condition that must hold at every rising clock edge outside reset.
`define HRLP_ASSERT_NOW(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
    else $error("hrlp assertion failed");

// Overlapping implication outside reset.
`define HRLP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("hrlp assertion failed");

// Next-cycle implication outside reset.
`define HRLP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("hrlp assertion failed");

`endif

>>> hw/rtl/hrlp_pkg.sv
// Shared types and constants for the HTTP request line parser.
// No dependencies.
package hrlp_pkg;

  localparam int unsigned MAX_REQUEST_BYTES = 1024;
  localparam int unsigned PATH_CAP_INT =
    (MAX_REQUEST_BYTES > 2047) ? 2047 : MAX_REQUEST_BYTES;
  localparam logic [10:0] PATH_COUNT_CAP = 11'(PATH_CAP_INT);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_METHOD,
    PH_PATH,
    PH_VERSION,
    PH_DONE
  } phase_e;

  localparam logic [2:0] CK_HTML  = 3'd0;
  localparam logic [2:0] CK_PLAIN = 3'd1;
  localparam logic [2:0] CK_CSS   = 3'd2;
  localparam logic [2:0] CK_PNG   = 3'd3;
  localparam logic [2:0] CK_JPEG  = 3'd4;

  localparam logic KIND_PATH    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_DOT = 8'h2e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [7:0] METHOD_TXT [3] = '{8'h47, 8'h45, 8'h54};           // GET
  localparam logic [7:0] VERSION_TXT [7] =
    '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2f, 8'h31, 8'h2e};                    // HTTP/1.

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_request;
  } in_item_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  path_byte;
    logic        request_valid;
    logic        version_minor;
    logic [2:0]  content_kind;
    logic        path_is_root;
    logic [10:0] path_length;
    logic        last_item;
  } out_item_t;

endpackage

>>> hw/rtl/hrlp_parse.sv
// Request line parser core: per-request state and the per-byte decision.
// Depends on hrlp_pkg.
module hrlp_parse import hrlp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  typedef struct packed {
    phase_e          phase;
    logic [3:0]      pos;
    logic            failed;
    logic            v11;
    logic [0:4][7:0] ext;
    logic [2:0]      ext_cnt;
    logic            ext_ovf;
    logic [10:0]     path_cnt;
    logic            first_slash;
    logic [1:0]      blank;
  } pstate_t;

  localparam pstate_t CLEAR = '{phase: PH_IDLE, default: '0};

  pstate_t st_q, st_d;

  function automatic logic ext_is(pstate_t s, logic [0:4][7:0] pat, logic [2:0] n);
    logic hit;
    hit = !s.ext_ovf && (s.ext_cnt == n);
    for (int i = 0; i < 5; i++) begin
      if (3'(i) < n && s.ext[i] != pat[i]) hit = 1'b0;
    end
    return hit;
  endfunction

  function automatic out_item_t verdict(pstate_t s, logic ok);
    out_item_t  r;
    logic       root;
    logic [2:0] ck;
    root = (s.path_cnt == 11'd0) || (s.path_cnt == 11'd1 && s.first_slash);
    if (ext_is(s, ".html", 3'd5) || ext_is(s, {".htm", 8'h00}, 3'd4)) ck = CK_HTML;
    else if (ext_is(s, {".css", 8'h00}, 3'd4)) ck = CK_CSS;
    else if (ext_is(s, {".png", 8'h00}, 3'd4)) ck = CK_PNG;
    else if (ext_is(s, {".jpg", 8'h00}, 3'd4)) ck = CK_JPEG;
    else ck = CK_PLAIN;
    r               = '0;
    r.item_kind     = KIND_VERDICT;
    r.request_valid = ok;
    r.version_minor = ok && s.v11;
    r.content_kind  = ok ? (root ? CK_HTML : ck) : CK_HTML;
    r.path_is_root  = ok && root;
    r.path_length   = s.path_cnt;
    r.last_item     = 1'b1;
    return r;
  endfunction

  always_comb begin
    logic [7:0] b;
    logic [7:0] expect_ch;
    logic       hdr_end;
    b           = item_i.data_byte;
    st_d        = st_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    hdr_end     = 1'b0;
    if (item_i.start_request) begin
      st_d       = CLEAR;
      st_d.phase = PH_METHOD;
    end
    if (st_d.phase == PH_METHOD || st_d.phase == PH_PATH || st_d.phase == PH_VERSION) begin
      // CR LF CR LF tracker
      expect_ch = st_d.blank[0] ? CH_LF : CH_CR;
      if (b == expect_ch) begin
        if (st_d.blank == 2'd3) hdr_end = 1'b1;
        else st_d.blank = st_d.blank + 2'd1;
      end else begin
        st_d.blank = (b == CH_CR) ? 2'd1 : 2'd0;
      end

      if (hdr_end) begin
        res_valid_o = 1'b1;
        res_o       = verdict(st_d, 1'b0);
        st_d.phase  = PH_DONE;
      end else begin
        case (st_d.phase)
          PH_METHOD: begin
            if (b == CH_SP) begin
              if (st_d.failed || st_d.pos != 4'd3) begin
                res_valid_o = 1'b1;
                res_o       = verdict(st_d, 1'b0);
                st_d.phase  = PH_DONE;
              end else begin
                st_d.pos    = '0;
                st_d.failed = 1'b0;
                st_d.phase  = PH_PATH;
              end
            end else begin
              if (st_d.pos >= 4'd3) st_d.failed = 1'b1;
              else begin
                if (METHOD_TXT[st_d.pos[1:0]] != b) st_d.failed = 1'b1;
                st_d.pos = st_d.pos + 4'd1;
              end
            end
          end
          PH_PATH: begin
            if (b == CH_SP) begin
              st_d.phase = PH_VERSION;
            end else begin
              if (st_d.path_cnt == 11'd0) st_d.first_slash = (b == CH_SLASH);
              if (st_d.path_cnt < PATH_COUNT_CAP) st_d.path_cnt = st_d.path_cnt + 11'd1;
              // text from the last dot, at most five bytes kept
              if (b == CH_DOT) begin
                st_d.ext     = {CH_DOT, 32'h0};
                st_d.ext_cnt = 3'd1;
                st_d.ext_ovf = 1'b0;
              end else if (st_d.ext_cnt != 3'd0) begin
                if (st_d.ext_cnt < 3'd5) begin
                  for (int i = 1; i < 5; i++) begin
                    if (st_d.ext_cnt == 3'(i)) st_d.ext[i] = b;
                  end
                  st_d.ext_cnt = st_d.ext_cnt + 3'd1;
                end else begin
                  st_d.ext_ovf = 1'b1;
                end
              end
              res_valid_o       = 1'b1;
              res_o.item_kind   = KIND_PATH;
              res_o.path_byte   = b;
              res_o.path_length = st_d.path_cnt;
            end
          end
          PH_VERSION: begin
            if (b == CH_CR) begin
              res_valid_o = 1'b1;
              res_o       = verdict(st_d, !st_d.failed && st_d.pos == 4'd8);
              st_d.phase  = PH_DONE;
            end else begin
              if (st_d.pos < 4'd7) begin
                if (VERSION_TXT[st_d.pos[2:0]] != b) st_d.failed = 1'b1;
              end else if (st_d.pos == 4'd7) begin
                if (b == CH_ONE) st_d.v11 = 1'b1;
                else if (b == CH_ZERO) st_d.v11 = 1'b0;
                else st_d.failed = 1'b1;
              end else begin
                st_d.failed = 1'b1;
              end
              if (st_d.pos < 4'd8) st_d.pos = st_d.pos + 4'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= CLEAR;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

endmodule

>>> hw/rtl/hrlp_outq.sv
// Two-entry result queue between the parser and the output channel.
// Depends on hrlp_pkg.
module hrlp_outq import hrlp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t push_data_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  out_item_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop         = (cnt_q != 2'd0) && !out_stall_i;
  assign full_o      = (cnt_q == 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) cnt_d = cnt_q + 2'd1;
    else if (!push_i && pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

>>> hw/rtl/http_request_line_parser.sv
// HTTP request line parser top level: parser core plus result queue.
// Depends on hrlp_pkg, hrlp_parse, hrlp_outq.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------
//  in      | in  | in_valid_i / in_stall_o | in_data_i  (in_item_t)
//  out     | out | out_valid_o / out_stall_i | out_data_o (out_item_t)
//
// One byte per clock while in_stall_o is low; each byte is decided in the
// cycle it is accepted and its result, if any, is registered in the queue.
// The two-entry result queue lets input keep flowing while the output stalls;
// in_stall_o rises only when both entries hold results.
// Reset returns the parser to idle and empties the queue; no clearing pass.
module http_request_line_parser import hrlp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic      accept;
  logic      res_valid;
  out_item_t res;
  logic      q_full;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  hrlp_parse u_parse (
    .clk_i,
    .rst_ni,
    .step_i      (accept),
    .item_i      (in_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  hrlp_outq u_outq (
    .clk_i,
    .rst_ni,
    .push_i      (accept && res_valid),
    .push_data_i (res),
    .full_o      (q_full),
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

endmodule

>>> hw/rtl/hrlp_checker.sv
// Port-level checker for the request line parser, bound to the top level.
// Depends on hrlp_pkg and http_request_line_parser_assert.svh.
`include "http_request_line_parser_assert.svh"

module hrlp_checker import hrlp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  logic out_wait;
  logic last_ok;
  logic bad_verdict;
  logic bad_clean;
  logic path_item;
  logic path_shape;

  assign out_wait    = out_valid_o && out_stall_i;
  assign last_ok     = (out_data_o.item_kind == out_data_o.last_item);
  assign bad_verdict = out_valid_o && out_data_o.item_kind && !out_data_o.request_valid;
  assign bad_clean   = !out_data_o.version_minor && (out_data_o.content_kind == CK_HTML) &&
                       !out_data_o.path_is_root;
  assign path_item   = out_valid_o && !out_data_o.item_kind;
  assign path_shape  = (out_data_o.path_length != 11'd0) &&
                       (out_data_o.path_length <= PATH_COUNT_CAP) &&
                       !out_data_o.request_valid;

  `HRLP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable(out_data_o))
  `HRLP_ASSERT_IMP(a_last_is_verdict, clk_i, rst_ni, out_valid_o, last_ok)
  `HRLP_ASSERT_IMP(a_bad_verdict_clean, clk_i, rst_ni, bad_verdict, bad_clean)
  `HRLP_ASSERT_IMP(a_path_item_shape, clk_i, rst_ni, path_item, path_shape)
  // input is held off only while both queue entries wait on the output
  `HRLP_ASSERT_IMP(a_full_has_item, clk_i, rst_ni, in_stall_o, out_valid_o)

endmodule

bind http_request_line_parser hrlp_checker u_hrlp_checker (.*);

>>> verif/request_line_checker.sv
// Output checker for the HTTP request line parser: predicts the results of each
// accepted byte and compares them with the items on the output channel.
// Depends on hrlp_pkg.
module request_line_checker import hrlp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  output int        mismatch_count_o,
  output int        pending_o
);

  localparam logic [23:0] METHOD_WORD  = "GET";
  localparam logic [55:0] VERSION_HEAD = "HTTP/1.";

  // predicted parser state
  phase_e      phase;
  logic [3:0]  match_pos;
  logic        match_bad;
  logic        minor_one;
  logic [7:0]  ext_chars [5];
  logic [2:0]  ext_len;
  logic        ext_long;
  logic [10:0] path_len;
  logic        leading_slash;
  logic [1:0]  crlf_run;

  out_item_t   parsed_q [$];
  out_item_t   produced_item;
  out_item_t   oldest;
  logic        produced;
  int          mismatches;

  function automatic void clear_request();
    match_pos     = '0;
    match_bad     = 1'b0;
    minor_one     = 1'b0;
    foreach (ext_chars[i]) ext_chars[i] = '0;
    ext_len       = '0;
    ext_long      = 1'b0;
    path_len      = '0;
    leading_slash = 1'b0;
    crlf_run      = '0;
  endfunction

  // text is right-aligned in 40 bits, n characters long
  function automatic logic ext_is(logic [39:0] text, int n);
    if (ext_long || int'(ext_len) != n) return 1'b0;
    for (int i = 0; i < n; i++)
      if (ext_chars[i] != text[8*(n-1-i) +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [2:0] kind_from_ext();
    if (ext_is(".html", 5) || ext_is(".htm", 4)) return CK_HTML;
    if (ext_is(".css", 4)) return CK_CSS;
    if (ext_is(".png", 4)) return CK_PNG;
    if (ext_is(".jpg", 4)) return CK_JPEG;
    return CK_PLAIN;
  endfunction

  function automatic void give_verdict(logic ok);
    logic root;
    root = (path_len == 0) || (path_len == 1 && leading_slash);
    produced = 1'b1;
    produced_item = '0;
    produced_item.item_kind     = KIND_VERDICT;
    produced_item.request_valid = ok;
    produced_item.version_minor = ok && minor_one;
    produced_item.content_kind  = (!ok || root) ? CK_HTML : kind_from_ext();
    produced_item.path_is_root  = ok && root;
    produced_item.path_length   = path_len;
    produced_item.last_item     = 1'b1;
    phase = PH_DONE;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic start);
    logic [7:0] want;
    produced = 1'b0;
    if (start) begin
      clear_request();
      phase = PH_METHOD;
    end
    if (!(phase == PH_METHOD || phase == PH_PATH || phase == PH_VERSION)) return;

    // blank line detection runs in every active phase
    want = crlf_run[0] ? CH_LF : CH_CR;
    if (b == want) begin
      if (crlf_run == 2'd3) begin
        give_verdict(1'b0);
        return;
      end
      crlf_run = crlf_run + 2'd1;
    end else begin
      crlf_run = (b == CH_CR) ? 2'd1 : 2'd0;
    end

    case (phase)
      PH_METHOD: begin
        if (b == CH_SP) begin
          if (match_bad || match_pos != 4'd3) give_verdict(1'b0);
          else begin
            match_pos = '0;
            match_bad = 1'b0;
            phase     = PH_PATH;
          end
        end else begin
          if (match_pos >= 4'd3 || METHOD_WORD[8*(2-int'(match_pos)) +: 8] != b)
            match_bad = 1'b1;
          if (match_pos < 4'd3) match_pos = match_pos + 4'd1;
        end
      end
      PH_PATH: begin
        if (b == CH_SP) phase = PH_VERSION;
        else begin
          if (path_len == 0) leading_slash = (b == CH_SLASH);
          if (path_len < PATH_COUNT_CAP) path_len = path_len + 11'd1;
          if (b == CH_DOT) begin
            foreach (ext_chars[i]) ext_chars[i] = '0;
            ext_chars[0] = b;
            ext_len      = 3'd1;
            ext_long     = 1'b0;
          end else if (ext_len != 0) begin
            if (ext_len < 3'd5) begin
              ext_chars[ext_len] = b;
              ext_len = ext_len + 3'd1;
            end else ext_long = 1'b1;
          end
          produced = 1'b1;
          produced_item = '0;
          produced_item.item_kind   = KIND_PATH;
          produced_item.path_byte   = b;
          produced_item.path_length = path_len;
        end
      end
      default: begin
        if (b == CH_CR) give_verdict(!match_bad && match_pos == 4'd8);
        else begin
          if (match_pos < 4'd7) begin
            if (VERSION_HEAD[8*(6-int'(match_pos)) +: 8] != b) match_bad = 1'b1;
          end else if (match_pos == 4'd7) begin
            if (b == CH_ONE) minor_one = 1'b1;
            else if (b == CH_ZERO) minor_one = 1'b0;
            else match_bad = 1'b1;
          end else match_bad = 1'b1;
          if (match_pos < 4'd8) match_pos = match_pos + 4'd1;
        end
      end
    endcase
  endtask

  function automatic string describe(out_item_t r);
    return $sformatf("kind=%0d byte=%02h valid=%0d minor=%0d ctype=%0d root=%0d len=%0d last=%0d",
                     r.item_kind, r.path_byte, r.request_valid, r.version_minor,
                     r.content_kind, r.path_is_root, r.path_length, r.last_item);
  endfunction

  function automatic void note_mismatch(string what, string exp_text, out_item_t got);
    if (mismatches < 10)
      $display("%0t: %s: expected %s, got %s", $realtime, what, exp_text, describe(got));
    mismatches++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase = PH_IDLE;
      clear_request();
      parsed_q.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        parse_byte(in_data_i.data_byte, in_data_i.start_request);
        if (produced) parsed_q.push_back(produced_item);
      end
      if (out_valid_i && !out_stall_i) begin
        if (parsed_q.size() == 0) note_mismatch("unexpected item", "nothing", out_data_i);
        else begin
          oldest = parsed_q.pop_front();
          if (oldest.item_kind     !== out_data_i.item_kind     ||
              oldest.path_byte     !== out_data_i.path_byte     ||
              oldest.request_valid !== out_data_i.request_valid ||
              oldest.version_minor !== out_data_i.version_minor ||
              oldest.content_kind  !== out_data_i.content_kind  ||
              oldest.path_is_root  !== out_data_i.path_is_root  ||
              oldest.path_length   !== out_data_i.path_length   ||
              oldest.last_item     !== out_data_i.last_item)
            note_mismatch("item mismatch", describe(oldest), out_data_i);
        end
      end
      mismatch_count_o <= mismatches;
      pending_o <= parsed_q.size();
    end
  end

endmodule

>>> verif/tb.sv
// Testbench top for the HTTP request line parser: clock, reset, request byte
// stimulus, output stall, watchdog and final verdict.
// Depends on hrlp_pkg, http_request_line_parser and request_line_checker.
module tb;
  import hrlp_pkg::*;

  localparam int QUIET_LIMIT     = 2000;
  localparam int BYTE_BUDGET     = 1400;
  localparam int CALM_FROM       = 1250;
  localparam int LONG_PATH_BYTES = 1030;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        mismatch_count;
  int        pending;

  logic       idle_on      = 1'b1;
  int         stall_left   = 0;
  int         quiet_cycles = 0;
  int         n_sent       = 0;
  logic [7:0] req_q [$];

  http_request_line_parser u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  request_line_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // receiver stalls in bursts of random length while idle_on is set
  always @(posedge clk_i) begin
    if (!idle_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 11) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] path_char();
    logic [7:0] b;
    if ($urandom_range(0, 3) != 0) return 8'h61 + 8'($urandom_range(0, 25));
    b = 8'($urandom);
    if (b == CH_SP) b = b ^ 8'h01;
    return b;
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) req_q.push_back(s[i]);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic first);
    int gap;
    gap = (idle_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, start_request: first};
    do @(posedge clk_i); while (!(in_valid && !in_stall));
    n_sent++;
  endtask

  task automatic send_request();
    foreach (req_q[i]) send_byte(req_q[i], i == 0);
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic push_path();
    int shape;
    shape = $urandom_range(0, 11);
    if (shape == 0) return;
    if (shape == 1) begin
      req_q.push_back(CH_SLASH);
      return;
    end
    if (shape != 2) req_q.push_back(CH_SLASH);
    repeat ($urandom_range(0, 10)) req_q.push_back(path_char());
    if ($urandom_range(0, 3) == 0) begin
      // earlier dot that a later one, if any, replaces
      req_q.push_back(CH_DOT);
      repeat ($urandom_range(0, 7)) req_q.push_back(path_char());
      if ($urandom_range(0, 1) != 0) req_q.push_back(CH_SLASH);
    end
    case ($urandom_range(0, 14))
      0:  push_text(".html");
      1:  push_text(".htm");
      2:  push_text(".css");
      3:  push_text(".png");
      4:  push_text(".jpg");
      5:  push_text(".HTML");
      6:  push_text(".htmlx");
      7:  push_text(".jpeg");
      8:  push_text(".");
      9:  push_text(".txt");
      10: push_text(".png.css");
      11: begin
        push_text(".htm");
        repeat ($urandom_range(1, 4)) req_q.push_back(path_char());
      end
      12: push_text(".Css");
      default: ;
    endcase
  endtask

  task automatic push_version();
    case ($urandom_range(0, 15))
      0: push_text("HTTP/1.2");
      1: push_text("HTTP/1.10");
      2: push_text("HTTP/1.");
      3: push_text("HTTP/2.0");
      4: push_text("http/1.1");
      5: repeat ($urandom_range(0, 9)) req_q.push_back(path_char());
      6: push_text("HTTP/1.1 ");
      default: push_text($urandom_range(0, 1) ? "HTTP/1.1" : "HTTP/1.0");
    endcase
  endtask

  task automatic build_request();
    int cut;
    req_q.delete();
    if ($urandom_range(0, 15) == 0) begin
      repeat ($urandom_range(1, 12)) req_q.push_back(8'($urandom));
      return;
    end
    case ($urandom_range(0, 15))
      0: push_text("POST");
      1: push_text("GE");
      2: push_text("GETT");
      3: push_text("get");
      4: ;
      5: repeat ($urandom_range(1, 4)) req_q.push_back(path_char());
      default: push_text("GET");
    endcase
    if ($urandom_range(0, 11) == 0) begin
      // header ends before the request line does
      if ($urandom_range(0, 1) != 0) begin
        req_q.push_back(CH_SP);
        push_path();
      end
      req_q.push_back(CH_CR);
      req_q.push_back(CH_LF);
      if ($urandom_range(0, 1) != 0) begin
        req_q.push_back(path_char());
        req_q.push_back(CH_CR);
        req_q.push_back(CH_LF);
      end
      req_q.push_back(CH_CR);
      req_q.push_back(CH_LF);
    end else begin
      req_q.push_back(CH_SP);
      push_path();
      req_q.push_back(CH_SP);
      push_version();
      req_q.push_back(CH_CR);
      if ($urandom_range(0, 5) == 0) begin
        req_q.push_back(CH_LF);
        repeat ($urandom_range(0, 4)) req_q.push_back(8'($urandom));
      end
    end
    // abandon the request midway; the next start drops it
    if ($urandom_range(0, 19) == 0) begin
      cut = $urandom_range(1, req_q.size());
      while (req_q.size() > cut) void'(req_q.pop_back());
    end
  endtask

  task automatic build_long_request();
    req_q.delete();
    push_text("GET /");
    repeat (LONG_PATH_BYTES) req_q.push_back(path_char());
    push_text(".png HTTP/1.1");
    req_q.push_back(CH_CR);
  endtask

  initial begin
    logic long_done;
    long_done = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // stray byte while idle, root request, byte after the verdict,
    // wrong method, blank line before any verdict
    send_byte(8'hff, 1'b0);
    req_q.delete();
    push_text("GET  HTTP/1.1");
    req_q.push_back(CH_CR);
    send_request();
    send_byte(8'h00, 1'b0);
    req_q.delete();
    push_text("PUT ");
    send_request();
    req_q = '{CH_CR, CH_LF, CH_CR, CH_LF};
    send_request();
    wait_results_done();

    while (n_sent < BYTE_BUDGET) begin
      if (n_sent >= CALM_FROM) idle_on <= 1'b0;
      else if ($urandom_range(0, 7) == 0) idle_on <= !idle_on;
      if (!long_done && n_sent > 150) begin
        build_long_request();
        long_done = 1'b1;
      end else begin
        build_request();
      end
      send_request();
      if ($urandom_range(0, 39) == 0) wait_results_done();
    end

    wait_results_done();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/hrlp_pkg.sv
hw/rtl/hrlp_parse.sv
hw/rtl/hrlp_outq.sv
hw/rtl/http_request_line_parser.sv
hw/rtl/hrlp_checker.sv
verif/request_line_checker.sv
verif/tb.sv
